/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the motion latch fade envelope unit.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mlfe_pkg.sv */
// Package of the motion latch fade envelope unit: widths, register indexes,
// reset values and the status type of the serial divider. No dependencies.
package mlfe_pkg;

   localparam int unsigned TIME_BITS      = 32;
   localparam int unsigned LEVEL_BITS     = 8;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = TIME_BITS;
   localparam int unsigned DIV_COUNT_BITS = $clog2(TIME_BITS);

   typedef logic [TIME_BITS-1:0]      time_type;
   typedef logic [LEVEL_BITS-1:0]     level_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam level_type LEVEL_MAX = {LEVEL_BITS{1'b1}};
   localparam level_type LEVEL_OFF = '0;

   localparam csr_index_type CSR_LATCH_TIME = 2'd0;
   localparam csr_index_type CSR_RISE_TIME  = 2'd1;
   localparam csr_index_type CSR_FALL_TIME  = 2'd2;

   localparam time_type LATCH_TIME_RESET = 32'd5000;
   localparam time_type RISE_TIME_RESET  = 32'd1000;
   localparam time_type FALL_TIME_RESET  = 32'd1000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/core/mlfe_channels.sv */
// Valid/ready channel interfaces for the request and response transfers.
// Depends on mlfe_pkg for the field types.
interface mlfe_req_if;
   logic               valid;
   logic               ready;
   mlfe_pkg::time_type now_ms;
   logic               motion;

   modport source(output valid, output now_ms, output motion, input ready);
   modport sink(input valid, input now_ms, input motion, output ready);
endinterface

interface mlfe_rsp_if;
   logic                valid;
   logic                ready;
   mlfe_pkg::level_type fade_level;
   logic                latched;

   modport source(output valid, output fade_level, output latched, input ready);
   modport sink(input valid, input fade_level, input latched, output ready);
endinterface

/* rtl/core/mlfe_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle through a shift register.
// Depends on mlfe_pkg; a zero divisor gives a quotient of zero.
module mlfe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mlfe_pkg::time_type         dividend,
   input  mlfe_pkg::time_type         divisor,
   output mlfe_pkg::time_type         quotient,
   output mlfe_pkg::div_status_type   status
);

   logic [mlfe_pkg::TIME_BITS-1:0]      rem_ff;
   logic [mlfe_pkg::TIME_BITS-1:0]      quot_ff;
   logic [mlfe_pkg::TIME_BITS-1:0]      dsr_ff;
   logic [mlfe_pkg::DIV_COUNT_BITS-1:0] count_ff;
   logic                                zero_ff;
   logic                                busy_ff;
   logic                                done_ff;

   logic [mlfe_pkg::TIME_BITS:0]   shifted;
   logic [mlfe_pkg::TIME_BITS+1:0] diff;
   logic                           fits;

   assign shifted = {rem_ff, quot_ff[mlfe_pkg::TIME_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign fits    = ~diff[mlfe_pkg::TIME_BITS+1];

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= dividend;
         dsr_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[mlfe_pkg::TIME_BITS-1:0] : shifted[mlfe_pkg::TIME_BITS-1:0];
         quot_ff <= {quot_ff[mlfe_pkg::TIME_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == mlfe_pkg::DIV_COUNT_BITS'(mlfe_pkg::TIME_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = zero_ff ? '0 : quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* rtl/core/motion_latch_fade_envelope_unit.sv */
// Top level of the motion latch fade envelope unit.
// Depends on mlfe_pkg, mlfe_channels (interfaces), mlfe_div and assert_macros.svh.
//
//   channel   direction   transfer carries
//   req       in          now_ms[31:0], motion
//   rsp       out         fade_level[7:0], latched
//   csr       in          csr_we, csr_index[1:0], csr_wdata[31:0]
//
// An item on a ramp goes through the prepare, classify, load, divide and final
// steps before the next ready; other items skip the load and divide steps.
// Reset is synchronous and restores the register defaults and the envelope state.
// A result waits in the output register; a new item is taken meanwhile, and its
// own result holds in the final step until the output register is free.
`include "assert_macros.svh"

module motion_latch_fade_envelope_unit (
   input  logic                          clock,
   input  logic                          reset,
   mlfe_req_if.sink                      req,
   mlfe_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  mlfe_pkg::csr_index_type       csr_index,
   input  logic [mlfe_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_CLASS = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   localparam logic [1:0] PH_RISE = 2'd0;
   localparam logic [1:0] PH_FALL = 2'd1;
   localparam logic [1:0] PH_MID  = 2'd2;
   localparam logic [1:0] PH_OFF  = 2'd3;

   localparam int unsigned TB = mlfe_pkg::TIME_BITS;
   localparam int unsigned LB = mlfe_pkg::LEVEL_BITS;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   mlfe_pkg::time_type  latch_ff, rise_ff, fall_ff;
   logic                prev_motion_ff;
   mlfe_pkg::time_type  trigger_ff, trigger_in;
   mlfe_pkg::level_type prev_level_ff;
   mlfe_pkg::time_type  elapsed_ff, elapsed_in;
   logic                clamp_ff, clamp_in;
   mlfe_pkg::time_type  rise_e_ff, rise_e_in;
   mlfe_pkg::time_type  fall_e_ff, fall_e_in;
   mlfe_pkg::time_type  fstart_ff, fstart_in;
   logic                lt_rise_ff, lt_rise_in;
   logic                lt_latch_ff, lt_latch_in;
   mlfe_pkg::time_type  fe_ff, fe_in;
   logic                rsp_valid_ff;
   mlfe_pkg::level_type level_ff, level_in;
   logic                latched_ff;

   logic                    req_fire;
   logic                    slot_free;
   logic                    ge_fstart;
   mlfe_pkg::time_type      span;
   mlfe_pkg::time_type      div_dividend;
   mlfe_pkg::time_type      div_divisor;
   mlfe_pkg::time_type      div_quot;
   mlfe_pkg::div_status_type div_stat;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // Elapsed time and the ramp clamp are formed in the transfer cycle.
   assign trigger_in = (req.motion && !prev_motion_ff) ? req.now_ms : trigger_ff;
   assign elapsed_in = req.now_ms - trigger_in;
   assign clamp_in   = (rise_ff + fall_ff) > latch_ff;

   assign rise_e_in   = clamp_ff ? {1'b0, latch_ff[TB-1:1]} : rise_ff;
   assign fall_e_in   = clamp_ff ? {1'b0, latch_ff[TB-1:1]} : fall_ff;
   assign fstart_in   = latch_ff - fall_e_in;
   assign lt_rise_in  = elapsed_ff < rise_e_in;
   assign lt_latch_in = elapsed_ff < latch_ff;

   assign ge_fstart = elapsed_ff >= fstart_ff;
   assign fe_in     = elapsed_ff - fstart_ff;

   always_comb begin
      if (lt_rise_ff) begin
         phase_in = PH_RISE;
      end else if (ge_fstart && lt_latch_ff) begin
         phase_in = PH_FALL;
      end else if (!ge_fstart) begin
         phase_in = PH_MID;
      end else begin
         phase_in = PH_OFF;
      end
   end

   // Multiplying by 255 is a shift by eight less the value itself.
   assign span         = (phase_ff == PH_RISE) ? elapsed_ff : fe_ff;
   assign div_dividend = {span[TB-LB-1:0], LB'(0)} - span;
   assign div_divisor  = (phase_ff == PH_RISE) ? rise_e_ff : fall_e_ff;

   mlfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_LOAD),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .status   (div_stat)
   );

   always_comb begin
      case (phase_ff)
         PH_RISE: begin
            level_in = (div_quot > {{(TB-LB){1'b0}}, prev_level_ff}) ?
                       div_quot[LB-1:0] : prev_level_ff;
         end
         PH_FALL: begin
            level_in = mlfe_pkg::LEVEL_MAX - div_quot[LB-1:0];
         end
         PH_MID: begin
            level_in = mlfe_pkg::LEVEL_MAX;
         end
         default: begin
            level_in = mlfe_pkg::LEVEL_OFF;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_CLASS;
         end
         S_CLASS: begin
            state_in = (phase_in == PH_RISE || phase_in == PH_FALL) ? S_LOAD : S_FIN;
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         latch_ff       <= mlfe_pkg::LATCH_TIME_RESET;
         rise_ff        <= mlfe_pkg::RISE_TIME_RESET;
         fall_ff        <= mlfe_pkg::FALL_TIME_RESET;
         prev_motion_ff <= 1'b0;
         trigger_ff     <= '0;
         prev_level_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               mlfe_pkg::CSR_LATCH_TIME: latch_ff <= csr_wdata;
               mlfe_pkg::CSR_RISE_TIME:  rise_ff  <= csr_wdata;
               mlfe_pkg::CSR_FALL_TIME:  fall_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_fire) begin
            prev_motion_ff <= req.motion;
            trigger_ff     <= trigger_in;
         end
         if (state_ff == S_FIN && slot_free) begin
            prev_level_ff <= level_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         elapsed_ff <= elapsed_in;
         clamp_ff   <= clamp_in;
      end
      if (state_ff == S_PREP) begin
         rise_e_ff   <= rise_e_in;
         fall_e_ff   <= fall_e_in;
         fstart_ff   <= fstart_in;
         lt_rise_ff  <= lt_rise_in;
         lt_latch_ff <= lt_latch_in;
      end
      if (state_ff == S_CLASS) begin
         phase_ff <= phase_in;
         fe_ff    <= fe_in;
      end
      if (state_ff == S_FIN && slot_free) begin
         level_ff   <= level_in;
         latched_ff <= lt_latch_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.fade_level = level_ff;
   assign rsp.latched    = latched_ff;

   `ASSERT_IMPLIES(a_ramp_quotient, clock, reset, state_ff == S_FIN && (phase_ff == PH_RISE || phase_ff == PH_FALL), div_quot < TB'(mlfe_pkg::LEVEL_MAX), "ramp quotient reached full scale")
   `ASSERT_IMPLIES(a_div_done_state, clock, reset, div_stat.done, state_ff == S_DIV, "divider finished outside the divide step")
   `ASSERT_NEXT(a_div_starts, clock, reset, state_ff == S_LOAD, div_stat.busy, "divider did not start after load")
   `ASSERT_IMPLIES(a_result_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FIN, "result raised outside the final step")

endmodule

/* sim/motion_latch_fade_envelope_unit_tb.sv */
// Self-checking testbench of the motion latch fade envelope unit: directed and random sensor
// samples over several register settings, checked against a predictor of the envelope.
// Depends on mlfe_pkg, the mlfe_req_if and mlfe_rsp_if interfaces and the unit itself.
module motion_latch_fade_envelope_unit_tb;
   import mlfe_pkg::*;

   localparam int unsigned HALF_PERIOD   = 10;
   localparam int unsigned RESET_CYCLES  = 5;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 48;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_ITEMS   = 110;
   localparam int unsigned STEADY_PHASE  = 3;
   localparam int unsigned REPORT_LIMIT  = 100;

   typedef struct packed {
      time_type now_ms;
      logic     motion;
   } sense_sample;

   typedef struct packed {
      level_type fade_level;
      logic      latched;
   } envelope_result;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic                     steady;
   int unsigned              cycle_count;
   int unsigned              fail_count;

   sense_sample    sample_queue[$];
   envelope_result envelope_due[$];
   sense_sample    taken_sample;
   sense_sample    next_sample;
   envelope_result owed;

   time_type  latch_len;
   time_type  rise_len;
   time_type  fall_len;
   logic      motion_seen;
   time_type  trigger_ms;
   level_type level_memory;

   mlfe_req_if req_ch();
   mlfe_rsp_if rsp_ch();

   motion_latch_fade_envelope_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic envelope_result predict_envelope(input sense_sample s);
      envelope_result r;
      time_type       ramp_up;
      time_type       ramp_down;
      time_type       elapsed;
      time_type       fall_start;
      time_type       product;
      time_type       quotient;
      ramp_up   = rise_len;
      ramp_down = fall_len;
      if (time_type'(ramp_up + ramp_down) > latch_len) begin
         ramp_up   = latch_len / 2;
         ramp_down = latch_len / 2;
      end
      if (s.motion && !motion_seen) begin
         trigger_ms = s.now_ms;
      end
      motion_seen = s.motion;
      elapsed     = s.now_ms - trigger_ms;
      fall_start  = latch_len - ramp_down;
      r.fade_level = LEVEL_OFF;
      if (elapsed < ramp_up) begin
         product  = elapsed * time_type'(LEVEL_MAX);
         quotient = product / ramp_up;
         r.fade_level = (quotient > time_type'(level_memory)) ?
                        quotient[LEVEL_BITS-1:0] : level_memory;
      end else if (elapsed >= fall_start && elapsed < latch_len) begin
         product  = (elapsed - fall_start) * time_type'(LEVEL_MAX);
         quotient = (ramp_down != '0) ? product / ramp_down : '0;
         r.fade_level = LEVEL_MAX - quotient[LEVEL_BITS-1:0];
      end else if (elapsed >= ramp_up && elapsed < fall_start) begin
         r.fade_level = LEVEL_MAX;
      end
      level_memory = r.fade_level;
      r.latched    = (elapsed < latch_len);
      return r;
   endfunction

   function automatic void add_sample(input time_type at_ms, input logic motion);
      sense_sample s;
      s.now_ms = at_ms;
      s.motion = motion;
      sample_queue.push_back(s);
   endfunction

   function automatic time_type random_span();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 16);
         1: return $urandom_range(100, 5000);
         2: return $urandom_range(10000, 2000000);
         3: return $urandom;
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   task automatic drain_block();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_ch.valid || envelope_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input time_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LATCH_TIME: latch_len = value;
         CSR_RISE_TIME:  rise_len  = value;
         CSR_FALL_TIME:  fall_len  = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input time_type latch, input time_type rise, input time_type fall);
      drain_block();
      write_reg(CSR_LATCH_TIME, latch);
      write_reg(CSR_RISE_TIME, rise);
      write_reg(CSR_FALL_TIME, fall);
      @(negedge clock);
   endtask

   // Each burst opens with a clean rising edge of motion and then samples the window
   // around the trigger; an occasional low motion bit breaks the burst and retriggers.
   task automatic random_phase(input int unsigned count);
      time_type        base;
      time_type        step;
      time_type        mark;
      longint unsigned span;
      longint unsigned wide;
      int unsigned     burst;
      int unsigned     made;
      made = 0;
      while (made < count) begin
         base = $urandom;
         add_sample(base - time_type'(1), 1'b0);
         add_sample(base, 1'b1);
         made += 2;
         burst = $urandom_range(4, 16);
         repeat (burst) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  span = longint'(latch_len) + latch_len / 4 + 2;
                  wide = {$urandom, $urandom};
                  step = time_type'(wide % span);
               end
               5, 6, 7: begin
                  case ($urandom_range(0, 3))
                     0: mark = rise_len;
                     1: mark = latch_len - fall_len;
                     2: mark = latch_len / 2;
                     default: mark = latch_len;
                  endcase
                  step = mark + time_type'($urandom_range(0, 4)) - time_type'(2);
               end
               default: step = $urandom;
            endcase
            add_sample(base + step, $urandom_range(0, 9) != 0);
            made++;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken_sample.now_ms = req_ch.now_ms;
            taken_sample.motion = req_ch.motion;
            envelope_due.push_back(predict_envelope(taken_sample));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
               next_sample = sample_queue.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.now_ms <= next_sample.now_ms;
               req_ch.motion <= next_sample.motion;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (envelope_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected transfer, expected none, actual level %0d latched %0b",
                           $time, rsp_ch.fade_level, rsp_ch.latched);
               end
            end else begin
               owed = envelope_due.pop_front();
               if (rsp_ch.fade_level !== owed.fade_level) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: fade_level expected %0d, actual %0d",
                              $time, owed.fade_level, rsp_ch.fade_level);
                  end
               end
               if (rsp_ch.latched !== owed.latched) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: latched expected %0b, actual %0b",
                              $time, owed.latched, rsp_ch.latched);
                  end
               end
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   initial begin
      time_type    pick_latch;
      time_type    pick_rise;
      time_type    pick_fall;
      int unsigned phase;
      clock         = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_LATCH_TIME;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.now_ms = '0;
      req_ch.motion = 1'b0;
      rsp_ch.ready  = 1'b0;
      steady        = 1'b0;
      cycle_count   = 0;
      fail_count    = 0;
      latch_len     = LATCH_TIME_RESET;
      rise_len      = RISE_TIME_RESET;
      fall_len      = FALL_TIME_RESET;
      motion_seen   = 1'b0;
      trigger_ms    = '0;
      level_memory  = LEVEL_OFF;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default window: every phase, both ramp ends, the timestamp wrapping and a
      // retrigger in the middle, where the rising ramp keeps the remembered level.
      add_sample(32'd0, 1'b0);
      add_sample(32'd100000, 1'b1);
      add_sample(32'd100500, 1'b1);
      add_sample(32'd101000, 1'b1);
      add_sample(32'd104000, 1'b1);
      add_sample(32'd104500, 1'b0);
      add_sample(32'd104999, 1'b0);
      add_sample(32'd105000, 1'b0);
      add_sample(32'hFFFF_FF00, 1'b1);
      add_sample(32'h0000_0100, 1'b1);
      add_sample(32'h0000_03FF, 1'b0);
      add_sample(32'h0000_0400, 1'b1);
      add_sample(32'hFFFF_FFFF, 1'b1);

      // Ramps whose sum exceeds the window are both cut to half of it.
      set_config(32'd3000, 32'd2000, 32'd2000);
      add_sample(32'd5000, 1'b0);
      add_sample(32'd5000, 1'b1);
      add_sample(32'd5750, 1'b1);
      add_sample(32'd7999, 1'b1);

      // The ramp sum wraps to zero; the rising product stays within range.
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      add_sample(32'd0, 1'b0);
      add_sample(32'h8000_0000, 1'b1);
      add_sample(32'h7FFF_FFFF, 1'b1);
      add_sample(32'h8100_0000, 1'b1);

      set_config(32'd0, 32'd0, 32'd0);
      add_sample(32'd12345, 1'b0);
      add_sample(32'd12345, 1'b1);

      set_config(32'd100, 32'd0, 32'd0);
      add_sample(32'd12400, 1'b0);
      add_sample(32'd12445, 1'b1);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_latch = random_span();
         if ($urandom_range(0, 9) < 7) begin
            pick_rise = pick_latch / $urandom_range(2, 6);
            pick_fall = pick_latch / $urandom_range(2, 6);
         end else begin
            pick_rise = random_span();
            pick_fall = random_span();
         end
         set_config(pick_latch, pick_rise, pick_fall);
         steady <= (phase == STEADY_PHASE);
         random_phase(PHASE_ITEMS);
      end

      drain_block();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
